// ===== hw/rtl/rrts_pkg.sv =====
// Shared types and codes for the round-robin tick scheduler.
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

   // Request action codes as carried on the input channel.
   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_SLEEP = 2'd1,
      ACT_WAKE  = 2'd2,
      ACT_LOAD  = 2'd3
   } action_type;

   // Per-slot thread state.
   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_RUN   = 2'd1,
      SLOT_SLEEP = 2'd2
   } slot_state_type;

   // Operation broadcast from the controller to every cell.
   typedef enum logic [2:0] {
      OP_NONE       = 3'd0,
      OP_COUNT      = 3'd1,
      OP_DEC_CUR    = 3'd2,
      OP_ZERO_CUR   = 3'd3,
      OP_SLEEP      = 3'd4,
      OP_WAKE       = 3'd5,
      OP_LOAD_RUN   = 3'd6,
      OP_LOAD_EMPTY = 3'd7
   } cell_op_type;

   // Controller to cell command group.
   typedef struct packed {
      cell_op_type op;
      logic        inject;   // place the search token at the start cell
      logic        pass;     // move the search token one cell along the ring
      logic        sweep;    // a search is in progress
   } cell_cmd_type;

   // Cell to controller status group; the controller ORs these over all cells.
   typedef struct packed {
      logic addr_empty;      // addressed slot is empty
      logic cur_run;         // current slot is runnable
      logic cur_keep;        // current slot is runnable with more than one tick left
      logic claim;           // token holder is runnable and takes the selection
   } cell_stat_type;

   localparam logic [31:0] TICKS_ONE = 32'd1;

endpackage

`default_nettype wire

// ===== hw/rtl/rrts_cell.sv =====
// One thread slot of the scheduler ring: state, tick counter, quantum and search token.
`timescale 1ns / 1ps
`default_nettype none

module rrts_cell
   import rrts_pkg::*;
#(
   parameter int IDX  = 0,
   parameter int IDXW = 4
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cell_cmd_type    cmd,
   input  wire logic [3:0]      thread,
   input  wire logic [31:0]     duration,
   input  wire logic [7:0]      quantum,
   input  wire logic [IDXW-1:0] cur_idx,
   input  wire logic [IDXW-1:0] start_idx,
   input  wire logic            tok_in,
   output logic                 tok_out,
   output cell_stat_type        stat
);

   slot_state_type state_ff, state_in;
   logic [31:0]    ticks_ff, ticks_in;
   logic [7:0]     quant_ff, quant_in;
   logic           tok_ff, tok_in_next;

   logic           hit;
   logic           is_cur;
   logic           is_run;
   logic [31:0]    fresh;
   logic [31:0]    fresh_load;

   // Address decode against this slot's fixed position.
   assign hit    = (32'(thread) == 32'(IDX));
   assign is_cur = (cur_idx == IDXW'(IDX));
   assign is_run = (state_ff == SLOT_RUN);

   // A quantum of zero still grants a single tick.
   assign fresh      = (quant_ff == 8'd0) ? TICKS_ONE : 32'(quant_ff);
   assign fresh_load = (quantum == 8'd0) ? TICKS_ONE : 32'(quantum);

   // Status reported back to the controller. The token is only on the ring while a
   // search is running, so a claim needs nothing from the command group.
   assign stat.addr_empty = hit && (state_ff == SLOT_EMPTY);
   assign stat.cur_run    = is_cur && is_run;
   assign stat.cur_keep   = is_cur && is_run && (ticks_ff > TICKS_ONE);
   assign stat.claim      = tok_ff && is_run;

   assign tok_out = tok_ff;

   // Token moves in from the previous cell, or is placed here at the start of a search.
   assign tok_in_next = (cmd.inject && (start_idx == IDXW'(IDX))) || (cmd.pass && tok_in);

   // Slot update for the broadcast operation and for a claim.
   always_comb begin
      state_in = state_ff;
      ticks_in = ticks_ff;
      quant_in = quant_ff;
      case (cmd.op)
         OP_COUNT: begin
            if (state_ff == SLOT_SLEEP) begin
               if (ticks_ff <= TICKS_ONE) begin
                  state_in = SLOT_RUN;
                  ticks_in = fresh;
               end else begin
                  ticks_in = ticks_ff - TICKS_ONE;
               end
            end
         end
         OP_DEC_CUR: begin
            if (is_cur) begin
               ticks_in = ticks_ff - TICKS_ONE;
            end
         end
         OP_ZERO_CUR: begin
            if (is_cur) begin
               ticks_in = '0;
            end
         end
         OP_SLEEP: begin
            if (hit) begin
               state_in = SLOT_SLEEP;
               ticks_in = duration;
            end
         end
         OP_WAKE: begin
            if (hit) begin
               state_in = SLOT_RUN;
               ticks_in = fresh;
            end
         end
         OP_LOAD_RUN: begin
            if (hit) begin
               state_in = SLOT_RUN;
               quant_in = quantum;
               ticks_in = fresh_load;
            end
         end
         OP_LOAD_EMPTY: begin
            if (hit) begin
               state_in = SLOT_EMPTY;
               quant_in = '0;
               ticks_in = '0;
            end
         end
         default: begin
         end
      endcase
      // A selected slot starts a fresh time slice.
      if (cmd.sweep && stat.claim) begin
         ticks_in = fresh;
      end
   end

   // Control state is reset; counter and quantum are written before use.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SLOT_EMPTY;
         tok_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         tok_ff   <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      ticks_ff <= ticks_in;
      quant_ff <= quant_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/round_robin_tick_scheduler.sv =====
// Top level of the round-robin tick scheduler: controller, cell ring and response register.
`timescale 1ns / 1ps
`default_nettype none

// Round-robin scheduler over SLOTS thread slots with sleep timers. Each slot is a cell
// in a ring; all cells count their sleep timers down in parallel on a tick, and the
// search for the next runnable slot is a token that moves one cell per clock around
// the ring, starting after the current slot and ending at it. One beat is taken at a
// time: sleep, wake and load pass through the execute and completion states; a tick
// that keeps the current thread passes through countdown, decision and completion; a
// tick or a sleep that triggers a search also walks the token around the ring. A
// finished response waits in its own register, so a slow consumer only holds the block
// once the next response is ready. No clearing pass is needed after reset.
module round_robin_tick_scheduler
   import rrts_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [3:0]  req_thread,
   input  wire logic [31:0] req_duration,
   input  wire logic [7:0]  req_quantum,
   input  wire logic        req_present,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_current_thread,
   output logic             rsp_running_idle,
   output logic             rsp_switched,
   output logic             rsp_status
);

   localparam int IDXW = $clog2(SLOTS);
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_COUNT = 6'b000010,
      S_CHECK = 6'b000100,
      S_EXEC  = 6'b001000,
      S_SWEEP = 6'b010000,
      S_DONE  = 6'b100000
   } sched_state_type;

   sched_state_type state_ff, state_in;

   action_type      act_ff, act_in;
   logic [3:0]      thr_ff, thr_in;
   logic [31:0]     dur_ff, dur_in;
   logic [7:0]      quant_ff, quant_in;
   logic            pres_ff, pres_in;

   logic [IDXW-1:0] cur_ff, cur_in;
   logic            idle_ff, idle_in;
   logic [IDXW-1:0] pos_ff, pos_in;
   logic [IDXW-1:0] hop_ff, hop_in;
   logic            switched_ff, switched_in;
   logic            status_ff, status_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [3:0]      rsp_thread_ff, rsp_thread_in;
   logic            rsp_idle_ff, rsp_idle_in;
   logic            rsp_switched_ff, rsp_switched_in;
   logic            rsp_status_ff, rsp_status_in;

   cell_cmd_type    cmd;
   cell_stat_type   stat [SLOTS];
   cell_stat_type   any;
   logic [SLOTS-1:0] tok_chain;

   logic            req_fire;
   logic            thr_valid;
   logic            thr_is_cur;
   logic [IDXW-1:0] next_idx;
   logic [31:0]     cur_ext;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;

   assign thr_valid  = (32'(thr_ff) < 32'(SLOTS));
   assign thr_is_cur = (32'(thr_ff) == 32'(cur_ff));
   assign next_idx   = (cur_ff == LAST_IDX) ? '0 : cur_ff + 1'b1;
   assign cur_ext    = 32'(cur_ff);

   // The ring of slot cells; each takes its token from the cell before it.
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      rrts_cell #(
         .IDX  (i),
         .IDXW (IDXW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .thread    (thr_ff),
         .duration  (dur_ff),
         .quantum   (quant_ff),
         .cur_idx   (cur_ff),
         .start_idx (next_idx),
         .tok_in    (tok_chain[(i + SLOTS - 1) % SLOTS]),
         .tok_out   (tok_chain[i]),
         .stat      (stat[i])
      );
   end

   // Combine cell status into one flag set.
   always_comb begin
      any = '0;
      for (int i = 0; i < SLOTS; i++) begin
         any = any | stat[i];
      end
   end

   // Sequencer: one beat at a time, countdown, decision, token search, response.
   always_comb begin
      state_in        = state_ff;
      act_in          = act_ff;
      thr_in          = thr_ff;
      dur_in          = dur_ff;
      quant_in        = quant_ff;
      pres_in         = pres_ff;
      cur_in          = cur_ff;
      idle_in         = idle_ff;
      pos_in          = pos_ff;
      hop_in          = hop_ff;
      switched_in     = switched_ff;
      status_in       = status_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_thread_in   = rsp_thread_ff;
      rsp_idle_in     = rsp_idle_ff;
      rsp_switched_in = rsp_switched_ff;
      rsp_status_in   = rsp_status_ff;
      cmd             = '{op: OP_NONE, inject: 1'b0, pass: 1'b0, sweep: 1'b0};

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               act_in      = action_type'(req_action);
               thr_in      = req_thread;
               dur_in      = req_duration;
               quant_in    = req_quantum;
               pres_in     = req_present;
               switched_in = 1'b0;
               status_in   = 1'b0;
               state_in    = (action_type'(req_action) == ACT_TICK) ? S_COUNT : S_EXEC;
            end
         end
         S_COUNT: begin
            cmd.op   = OP_COUNT;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!idle_ff && any.cur_keep) begin
               cmd.op   = OP_DEC_CUR;
               state_in = S_DONE;
            end else begin
               if (!idle_ff && any.cur_run) begin
                  cmd.op = OP_ZERO_CUR;
               end
               cmd.inject  = 1'b1;
               pos_in      = next_idx;
               hop_in      = '0;
               switched_in = 1'b1;
               state_in    = S_SWEEP;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (act_ff)
               ACT_LOAD: begin
                  if (!thr_valid) begin
                     status_in = 1'b1;
                  end else begin
                     cmd.op = pres_ff ? OP_LOAD_RUN : OP_LOAD_EMPTY;
                  end
               end
               ACT_SLEEP: begin
                  if (!thr_valid || any.addr_empty) begin
                     status_in = 1'b1;
                  end else begin
                     cmd.op = OP_SLEEP;
                     // Putting the running slot to sleep selects another at once.
                     if (!idle_ff && thr_is_cur) begin
                        cmd.inject  = 1'b1;
                        pos_in      = next_idx;
                        hop_in      = '0;
                        switched_in = 1'b1;
                        state_in    = S_SWEEP;
                     end
                  end
               end
               ACT_WAKE: begin
                  if (!thr_valid || any.addr_empty) begin
                     status_in = 1'b1;
                  end else begin
                     cmd.op = OP_WAKE;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (any.claim) begin
               cur_in   = pos_ff;
               idle_in  = 1'b0;
               state_in = S_DONE;
            end else if (hop_ff == LAST_IDX) begin
               idle_in  = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.pass = 1'b1;
               pos_in   = (pos_ff == LAST_IDX) ? '0 : pos_ff + 1'b1;
               hop_in   = hop_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_thread_in   = idle_ff ? 4'd0 : cur_ext[3:0];
               rsp_idle_in     = idle_ff;
               rsp_switched_in = switched_ff;
               rsp_status_in   = status_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         idle_ff      <= 1'b1;
         pos_ff       <= '0;
         hop_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         idle_ff      <= idle_in;
         pos_ff       <= pos_in;
         hop_ff       <= hop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Beat payload and response payload registers.
   always_ff @(posedge clock) begin
      act_ff          <= act_in;
      thr_ff          <= thr_in;
      dur_ff          <= dur_in;
      quant_ff        <= quant_in;
      pres_ff         <= pres_in;
      switched_ff     <= switched_in;
      status_ff       <= status_in;
      rsp_thread_ff   <= rsp_thread_in;
      rsp_idle_ff     <= rsp_idle_in;
      rsp_switched_ff <= rsp_switched_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_current_thread = rsp_thread_ff;
   assign rsp_running_idle   = rsp_idle_ff;
   assign rsp_switched       = rsp_switched_ff;
   assign rsp_status         = rsp_status_ff;

   // At most one search token is ever on the ring.
   a_one_token : assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_chain))
      else $error("more than one search token on the ring");

   // During a search the token sits at the position the controller tracks.
   a_token_at_pos : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP) |-> tok_chain[pos_ff])
      else $error("search token out of step with search position");

   // A claim ends the search with a thread selected.
   a_claim_selects : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP && any.claim) |=> (!idle_ff && state_ff == S_DONE))
      else $error("claim did not select a thread");

   // A response is only raised from the completion state.
   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside completion");

endmodule

`default_nettype wire
